### sv/ael_pkg.sv
package ael_pkg;

  // Width of the character position counter
  localparam int POS_BITS = 16;
  // Width of the start and span fields on the result stream
  localparam int FIELD_POS_W = 16;

  // Token kinds as they appear on the result stream
  typedef enum logic [2:0] {
    KIND_INT   = 3'd0,
    KIND_DEC   = 3'd1,
    KIND_NAME  = 3'd2,
    KIND_OP    = 3'd3,
    KIND_UNARY = 3'd4,
    KIND_SEMI  = 3'd5,
    KIND_ERR   = 3'd6
  } kind_t;

  // Character codes the lexer tests against
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_DIG_LO = 8'h30;
  localparam logic [7:0] CH_DIG_HI = 8'h39;
  localparam logic [7:0] CH_UC_LO  = 8'h41;
  localparam logic [7:0] CH_UC_HI  = 8'h5A;
  localparam logic [7:0] CH_LC_LO  = 8'h61;
  localparam logic [7:0] CH_LC_HI  = 8'h7A;

  // One token as produced by the lexer
  typedef struct packed {
    kind_t                  kind;
    logic [FIELD_POS_W-1:0] start;
    logic [FIELD_POS_W-1:0] span;
    logic [7:0]             opc;
  } tok_t;

  // One result item: a token plus the flag for the last result of an input item
  typedef struct packed {
    logic last;
    tok_t tok;
  } res_t;

  function automatic tok_t mk_tok(kind_t kind, logic [POS_BITS-1:0] start,
                                  logic [POS_BITS-1:0] span, logic [7:0] opc);
    tok_t t;
    t.kind  = kind;
    t.start = FIELD_POS_W'(start);
    t.span  = FIELD_POS_W'(span);
    t.opc   = opc;
    return t;
  endfunction

endpackage

### sv/ael_lex_core.sv
module ael_lex_core import ael_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] char_code,
  input  logic       end_of_text,
  output logic [1:0] res_count,
  output res_t       res0,
  output res_t       res1
);

  typedef enum logic [5:0] {
    ST_START = 6'b000001,
    ST_INT   = 6'b000010,
    ST_OP    = 6'b000100,
    ST_DOT   = 6'b001000,
    ST_FRAC  = 6'b010000,
    ST_NAME  = 6'b100000
  } lex_state_t;

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  lex_state_t          lex_state, lex_state_next;
  logic [POS_BITS-1:0] token_start, token_start_next;
  logic [POS_BITS-1:0] char_index, char_index_next;
  logic                any_emitted, any_emitted_next;
  logic                error_hold, error_hold_next;

  logic [7:0]          c;
  logic                is_dig, is_name, is_op, is_sep, is_semi, is_dot, is_rparen, is_pm;
  logic                ends_tok;
  logic [POS_BITS-1:0] span;
  tok_t                t0, t1;
  logic [1:0]          n;

  // Classify the current character; end of text reads as a space
  always_comb begin
    c         = end_of_text ? CH_SPACE : char_code;
    is_dig    = c inside {[CH_DIG_LO:CH_DIG_HI]};
    is_name   = (c == CH_UNDER) || (c inside {[CH_UC_LO:CH_UC_HI]}) ||
                (c inside {[CH_LC_LO:CH_LC_HI]});
    is_op     = c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LPAREN, CH_RPAREN,
                          CH_EQUAL};
    is_sep    = c inside {CH_SPACE, CH_TAB, CH_LF};
    is_semi   = (c == CH_SEMI);
    is_dot    = (c == CH_DOT);
    is_rparen = (c == CH_RPAREN);
    is_pm     = (c == CH_PLUS) || (c == CH_MINUS);
    ends_tok  = is_op || is_sep || is_semi;
    span      = char_index - token_start;
  end

  // Next state and tokens for the item at the lexer input
  always_comb begin
    lex_state_next   = lex_state;
    token_start_next = token_start;
    error_hold_next  = error_hold;
    n  = 2'd0;
    t0 = '0;
    t1 = '0;

    if (!error_hold) begin
      case (lex_state)
        ST_INT, ST_FRAC, ST_NAME: begin
          if (is_dig || (lex_state == ST_NAME && is_name)) begin
            // stay inside the pending token
          end else if (lex_state == ST_INT && is_dot) begin
            lex_state_next = ST_DOT;
          end else if (ends_tok || (lex_state == ST_NAME && is_dot)) begin
            // close the pending token, then handle the terminating character
            n  = 2'd1;
            t0 = mk_tok((lex_state == ST_INT) ? KIND_INT :
                        (lex_state == ST_FRAC) ? KIND_DEC : KIND_NAME,
                        token_start, span, 8'h00);
            token_start_next = char_index;
            if (is_rparen) begin
              n  = 2'd2;
              t1 = mk_tok(KIND_OP, char_index, POS_BITS'(1), c);
              lex_state_next = ST_START;
            end else if (is_op) begin
              n  = 2'd2;
              t1 = mk_tok(KIND_OP, char_index, POS_BITS'(1), c);
              lex_state_next = ST_OP;
            end else if (is_sep) begin
              lex_state_next = ST_START;
            end else if (is_dot) begin
              lex_state_next = ST_DOT;
            end else begin
              n  = 2'd2;
              t1 = mk_tok(KIND_SEMI, char_index, POS_BITS'(1), c);
              lex_state_next = ST_OP;
            end
          end else begin
            n  = 2'd1;
            t0 = mk_tok(KIND_ERR, char_index, POS_BITS'(1), c);
            error_hold_next = 1'b1;
          end
        end
        ST_DOT: begin
          if (is_dig) begin
            lex_state_next = ST_FRAC;
          end else begin
            n  = 2'd1;
            t0 = mk_tok(KIND_ERR, char_index, POS_BITS'(1), c);
            error_hold_next = 1'b1;
          end
        end
        default: begin
          // start state or after an operator: nothing pending
          lex_state_next = (lex_state == ST_OP) ? ST_OP : ST_START;
          if (is_dig) begin
            token_start_next = char_index;
            lex_state_next   = ST_INT;
          end else if (is_name) begin
            token_start_next = char_index;
            lex_state_next   = ST_NAME;
          end else if (is_dot) begin
            token_start_next = char_index;
            lex_state_next   = ST_DOT;
          end else if (is_rparen) begin
            token_start_next = char_index;
            n  = 2'd1;
            t0 = mk_tok(KIND_OP, char_index, POS_BITS'(1), c);
            lex_state_next = ST_START;
          end else if (is_pm) begin
            token_start_next = char_index;
            n  = 2'd1;
            t0 = mk_tok((lex_state == ST_OP || !any_emitted) ? KIND_UNARY : KIND_OP,
                        char_index, POS_BITS'(1), c);
            lex_state_next = ST_OP;
          end else if (is_op) begin
            token_start_next = char_index;
            n  = 2'd1;
            t0 = mk_tok(KIND_OP, char_index, POS_BITS'(1), c);
            lex_state_next = ST_OP;
          end else if (is_sep) begin
            // skip separator
          end else if (is_semi) begin
            token_start_next = char_index;
            n  = 2'd1;
            t0 = mk_tok(KIND_SEMI, char_index, POS_BITS'(1), c);
            lex_state_next = ST_OP;
          end else begin
            n  = 2'd1;
            t0 = mk_tok(KIND_ERR, char_index, POS_BITS'(1), c);
            error_hold_next = 1'b1;
          end
        end
      endcase
    end

    any_emitted_next = any_emitted || ((n != 2'd0) && (t0.kind != KIND_ERR));

    // Advance the position, saturating; hold it while an error is held
    if (error_hold) begin
      char_index_next = char_index;
    end else if (char_index != POS_MAX) begin
      char_index_next = char_index + POS_BITS'(1);
    end else begin
      char_index_next = char_index;
    end

    // End of text returns everything to reset
    if (end_of_text) begin
      lex_state_next   = ST_START;
      token_start_next = '0;
      char_index_next  = '0;
      any_emitted_next = 1'b0;
      error_hold_next  = 1'b0;
    end
  end

  assign res_count = n;
  assign res0 = '{last: (n == 2'd1), tok: t0};
  assign res1 = '{last: 1'b1, tok: t1};

  // Update lexer state when an item is consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      lex_state   <= ST_START;
      token_start <= '0;
      char_index  <= '0;
      any_emitted <= 1'b0;
      error_hold  <= 1'b0;
    end else if (step) begin
      lex_state   <= lex_state_next;
      token_start <= token_start_next;
      char_index  <= char_index_next;
      any_emitted <= any_emitted_next;
      error_hold  <= error_hold_next;
    end
  end

endmodule

### sv/ael_result_buf.sv
module ael_result_buf import ael_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  logic [1:0] load_count,
  input  res_t       load0,
  input  res_t       load1,
  output logic       room,
  output logic       out_valid,
  input  logic       out_ready,
  output res_t       out_res
);

  res_t       slot_a, slot_b;
  logic [1:0] cnt;
  logic       pop;

  assign pop       = (cnt != 2'd0) && out_ready;
  assign room      = (cnt == 2'd0) || ((cnt == 2'd1) && out_ready);
  assign out_valid = (cnt != 2'd0);
  assign out_res   = slot_a;

  // Load one or two new results, or shift the second slot to the head
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= load_count;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_a <= load0;
      slot_b <= load1;
    end else if (pop) begin
      slot_a <= slot_b;
    end
  end

endmodule

### sv/arith_expr_lexer.sv
// Arithmetic expression lexer. Characters arrive one per item on the slave
// stream (tdata = ASCII code, tlast = end of text, which acts as a closing
// space and then resets the lexer and the position counter). Tokens leave on
// the master stream with kind, start position, span length and operator
// character; tlast marks the final token caused by one input item. An input
// item is taken every cycle as long as it yields at most one token and the
// master stream does not stall; an item that closes a pending number or name
// and also yields an operator or ';' gives two tokens, which the two-slot
// result buffer sends one after the other, so items that yield tokens wait
// until it has room. Tokens pass the input register, then the result buffer.
module arith_expr_lexer import ael_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tlast,   // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [2:0] token_kind, [18:3] start_pos,
                                 // [34:19] span_length, [42:35] op_char, rest zero
  output logic        m_tlast    // last_in_run
);

  logic       in_valid;
  logic [7:0] in_char;
  logic       in_eot;
  logic       step;
  logic       room;
  logic [1:0] res_count;
  res_t       res0, res1, out_res;

  // Consume the held item when its tokens fit in the result buffer
  assign step     = in_valid && ((res_count == 2'd0) || room);
  assign s_tready = !in_valid || step;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata;
      in_eot  <= s_tlast;
    end
  end

  ael_lex_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .char_code   (in_char),
    .end_of_text (in_eot),
    .res_count   (res_count),
    .res0        (res0),
    .res1        (res1)
  );

  ael_result_buf u_buf (
    .clk        (clk),
    .rst        (rst),
    .load       (step && (res_count != 2'd0)),
    .load_count (res_count),
    .load0      (res0),
    .load1      (res1),
    .room       (room),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_res    (out_res)
  );

  // Pack the head token onto the master stream
  assign m_tdata = {5'd0, out_res.tok.opc, out_res.tok.span, out_res.tok.start,
                    out_res.tok.kind};
  assign m_tlast = out_res.last;

endmodule

### test/tb_lexer_check_pkg.sv
package tb_lexer_check_pkg;
  import ael_pkg::*;

  // Lexer states as the checker tracks them
  typedef enum logic [2:0] {
    LX_START    = 3'd0,
    LX_INT      = 3'd1,
    LX_AFTER_OP = 3'd2,
    LX_DOT      = 3'd3,
    LX_FRAC     = 3'd4,
    LX_NAME     = 3'd5
  } lex_phase_t;

  // One token the lexer should send
  typedef struct {
    kind_t       kind;
    logic [15:0] start;
    logic [15:0] span;
    logic [7:0]  opc;
    logic        last;
  } token_exp_t;

  class token_scoreboard;
    lex_phase_t            st;
    logic [POS_BITS-1:0]   tok_begin;
    logic [POS_BITS-1:0]   pos;
    bit                    seen_token;
    bit                    halted;
    token_exp_t            pending[$];
    int                    fails;

    function new();
      restart();
      fails = 0;
    endfunction

    function void restart();
      st         = LX_START;
      tok_begin  = '0;
      pos        = '0;
      seen_token = 0;
      halted     = 0;
    endfunction

    static function bit is_digit(logic [7:0] c);
      return c >= CH_DIG_LO && c <= CH_DIG_HI;
    endfunction

    static function bit is_alpha(logic [7:0] c);
      return c == CH_UNDER || (c >= CH_UC_LO && c <= CH_UC_HI) ||
             (c >= CH_LC_LO && c <= CH_LC_HI);
    endfunction

    static function bit is_op(logic [7:0] c);
      return c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LPAREN, CH_RPAREN,
                       CH_EQUAL};
    endfunction

    static function bit is_sep(logic [7:0] c);
      return c inside {CH_SPACE, CH_TAB, CH_LF};
    endfunction

    static function bit ends_token(logic [7:0] c);
      return is_op(c) || is_sep(c) || c == CH_SEMI;
    endfunction

    function void add_token(kind_t k, logic [15:0] s, logic [15:0] sp, logic [7:0] oc);
      token_exp_t t;
      t.kind  = k;
      t.start = s;
      t.span  = sp;
      t.opc   = oc;
      t.last  = 1'b0;
      pending.push_back(t);
      if (k != KIND_ERR) seen_token = 1;
    endfunction

    function void flag_error(logic [15:0] i, logic [7:0] c);
      add_token(KIND_ERR, i, 16'd1, c);
      halted = 1;
    endfunction

    // Nothing pending: start a token, emit a one-character token, skip a separator or flag an error
    function void from_rest(logic [15:0] i, logic [7:0] c);
      bit unary;
      unary = (st == LX_AFTER_OP) || !seen_token;
      if (is_digit(c)) begin
        tok_begin = i;
        st = LX_INT;
      end else if (is_alpha(c)) begin
        tok_begin = i;
        st = LX_NAME;
      end else if (c == CH_DOT) begin
        tok_begin = i;
        st = LX_DOT;
      end else if (c == CH_RPAREN) begin
        tok_begin = i;
        add_token(KIND_OP, i, 16'd1, c);
        st = LX_START;
      end else if (c == CH_PLUS || c == CH_MINUS) begin
        tok_begin = i;
        add_token(unary ? KIND_UNARY : KIND_OP, i, 16'd1, c);
        st = LX_AFTER_OP;
      end else if (is_op(c)) begin
        tok_begin = i;
        add_token(KIND_OP, i, 16'd1, c);
        st = LX_AFTER_OP;
      end else if (c == CH_SEMI) begin
        tok_begin = i;
        add_token(KIND_SEMI, i, 16'd1, c);
        st = LX_AFTER_OP;
      end else if (!is_sep(c)) begin
        flag_error(i, c);
      end
    endfunction

    // Close the pending number or name, then handle the closing character
    function void close_tok(logic [15:0] i, logic [7:0] c, kind_t k);
      add_token(k, tok_begin, i - tok_begin, 8'h00);
      tok_begin = i;
      if (c == CH_RPAREN) begin
        add_token(KIND_OP, i, 16'd1, c);
        st = LX_START;
      end else if (is_op(c)) begin
        add_token(KIND_OP, i, 16'd1, c);
        st = LX_AFTER_OP;
      end else if (is_sep(c)) begin
        st = LX_START;
      end else if (c == CH_DOT) begin
        st = LX_DOT;
      end else begin
        add_token(KIND_SEMI, i, 16'd1, c);
        st = LX_AFTER_OP;
      end
    endfunction

    // Advance the lexer by one accepted character and queue its tokens
    function void note_char(logic [7:0] code, logic eot);
      logic [7:0]          c;
      logic [POS_BITS-1:0] i;
      int                  before_n;
      token_exp_t          t;
      c = eot ? CH_SPACE : code;
      i = pos;
      before_n = pending.size();
      if (halted) begin
        if (eot) restart();
        return;
      end
      case (st)
        LX_INT: begin
          if (c == CH_DOT) st = LX_DOT;
          else if (!is_digit(c)) begin
            if (ends_token(c)) close_tok(i, c, KIND_INT);
            else flag_error(i, c);
          end
        end
        LX_DOT: begin
          if (is_digit(c)) st = LX_FRAC;
          else flag_error(i, c);
        end
        LX_FRAC: begin
          if (!is_digit(c)) begin
            if (ends_token(c)) close_tok(i, c, KIND_DEC);
            else flag_error(i, c);
          end
        end
        LX_NAME: begin
          if (!is_digit(c) && !is_alpha(c)) begin
            if (ends_token(c) || c == CH_DOT) close_tok(i, c, KIND_NAME);
            else flag_error(i, c);
          end
        end
        LX_AFTER_OP: from_rest(i, c);
        default: begin
          st = LX_START;
          from_rest(i, c);
        end
      endcase
      // Mark the final token of this item
      if (pending.size() > before_n) begin
        t = pending.pop_back();
        t.last = 1'b1;
        pending.push_back(t);
      end
      if (eot) restart();
      else if (pos != '1) pos++;
    endfunction

    // Compare one sent token with the oldest one waiting
    function void check_token(logic [47:0] data, logic last);
      token_exp_t w;
      if (pending.size() == 0) begin
        $error("token sent with none expected: tdata %h tlast %b", data, last);
        fails++;
        return;
      end
      w = pending.pop_front();
      if (data[2:0] !== w.kind) begin
        $error("token_kind expected %0d actual %0d", w.kind, data[2:0]);
        fails++;
      end
      if (data[18:3] !== w.start) begin
        $error("start_pos expected %0d actual %0d", w.start, data[18:3]);
        fails++;
      end
      if (data[34:19] !== w.span) begin
        $error("span_length expected %0d actual %0d", w.span, data[34:19]);
        fails++;
      end
      if (data[42:35] !== w.opc) begin
        $error("op_char expected %h actual %h", w.opc, data[42:35]);
        fails++;
      end
      if (last !== w.last) begin
        $error("last_in_run expected %b actual %b", w.last, last);
        fails++;
      end
    endfunction
  endclass

endpackage

### test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ael_pkg::*;
  import tb_lexer_check_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [47:0] m_tdata;
  logic        m_tlast;

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  logic [7:0] expr_chars[$];
  token_scoreboard book = new();

  always #5 clk = ~clk;

  arith_expr_lexer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Watch both streams at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) book.note_char(s_tdata, s_tlast);
      if (m_tvalid && m_tready) book.check_token(m_tdata, m_tlast);
    end
  end

  // Token receiver: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one item and hold it until taken
  task automatic send_char(input logic [7:0] c, input logic eot);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= eot;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_str(input string s);
    for (int k = 0; k < s.len(); k++) send_char(s[k], 1'b0);
  endtask

  function automatic logic [7:0] pick_letter();
    case ($urandom_range(2))
      0: return CH_UNDER;
      1: return 8'(CH_UC_LO + $urandom_range(25));
      default: return 8'(CH_LC_LO + $urandom_range(25));
    endcase
  endfunction

  function automatic void put_digits(int n);
    repeat (n) expr_chars.push_back(8'(CH_DIG_LO + $urandom_range(9)));
  endfunction

  function automatic void put_gap();
    case ($urandom_range(5))
      0: expr_chars.push_back(CH_TAB);
      1: expr_chars.push_back(CH_LF);
      2, 3: expr_chars.push_back(CH_SPACE);
      default: ;
    endcase
  endfunction

  // Integer, decimal or name operand, sometimes opened by '(' and signed
  function automatic void put_operand();
    if ($urandom_range(4) == 0) expr_chars.push_back(CH_LPAREN);
    if ($urandom_range(5) == 0) expr_chars.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
    case ($urandom_range(2))
      0: put_digits($urandom_range(1, 4));
      1: begin
        put_digits($urandom_range(0, 3));
        expr_chars.push_back(CH_DOT);
        put_digits($urandom_range(1, 3));
      end
      default: begin
        expr_chars.push_back(pick_letter());
        repeat ($urandom_range(5))
          expr_chars.push_back($urandom_range(2) == 0 ? 8'(CH_DIG_LO + $urandom_range(9))
                                                      : pick_letter());
      end
    endcase
    if ($urandom_range(4) == 0) expr_chars.push_back(CH_RPAREN);
  endfunction

  // Build one expression with random content; some get broken
  function automatic void build_expr();
    logic [7:0] ops[5];
    ops = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_EQUAL};
    expr_chars.delete();
    put_gap();
    put_operand();
    repeat ($urandom_range(4)) begin
      put_gap();
      expr_chars.push_back(ops[$urandom_range(4)]);
      put_gap();
      put_operand();
    end
    put_gap();
    if ($urandom_range(2) != 0) expr_chars.push_back(CH_SEMI);
    if ($urandom_range(99) < 15)
      expr_chars.insert($urandom_range(expr_chars.size()), 8'($urandom_range(255)));
    if ($urandom_range(99) < 5) expr_chars.push_back(CH_DOT);
  endfunction

  // Stimulus
  initial begin : stim
    int idle_set[4];
    int stall_set[4];
    int sent;
    bit held;
    idle_set  = '{0, 72, 0, 22};
    stall_set = '{0, 0, 72, 22};
    held = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Unary first sign, int closed by an operator, name closed by a tab, ';'
    send_str("-1+x\t;");
    send_char(8'hA5, 1'b1);
    // Decimal without integer part, binary '-' after ')', dot after a fraction,
    // input ignored while in error, end of text while in error
    send_str("(.5)-2.5.7");
    send_char(8'h00, 1'b1);
    // Name closed by '=', newline, lone dot closed by end of text
    send_str("a=\n.");
    send_char(8'h00, 1'b1);
    // Lowest byte as an unexpected character
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h7E, 1'b1);

    // Long name closed by a binary '+', int closed by a space, ';'
    send_str("abcdefghij+12 ;");
    send_char(8'h00, 1'b1);

    // Random expressions across the idling phases
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_set[ph];
      stall_pct = stall_set[ph];
      sent = 0;
      while (sent < 225) begin
        build_expr();
        // Long receiver hold-off while the sender keeps offering
        if (ph == 0 && sent >= 100 && !held) begin
          hold_left = 300;
          held = 1'b1;
        end
        foreach (expr_chars[k]) send_char(expr_chars[k], 1'b0);
        send_char(8'($urandom_range(255)), 1'b1);
        sent += expr_chars.size() + 1;
      end
    end
    s_tvalid <= 1'b0;

    // Drain and let the pipeline settle
    while (book.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (book.fails == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### files.f
sv/ael_pkg.sv
sv/ael_lex_core.sv
sv/ael_result_buf.sv
sv/arith_expr_lexer.sv
test/tb_lexer_check_pkg.sv
test/tb_top.sv
